FILE: rtl/media_command_stream_parser_macros.svh
// Assertion macros used by the checker of the media command stream parser.
`ifndef MEDIA_COMMAND_STREAM_PARSER_MACROS_SVH
`define MEDIA_COMMAND_STREAM_PARSER_MACROS_SVH

// Property that must hold at every edge outside reset.
`define MCSP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in a cycle implies consequent in the next.
`define MCSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mcsp_pkg.sv
// Shared constants and result type of the media command stream parser.
package mcsp_pkg;

  localparam logic [7:0] CMD_MEDIA_TIME = 8'd17;
  localparam logic [7:0] SUB_FLUSH      = 8'd22;
  localparam logic [7:0] SUB_PUSH       = 8'd23;
  localparam logic [7:0] CMD_NEW_CELL   = 8'd41;

  localparam int PUSH_RECORD_LEN = 16;
  localparam int HEADER_LEN      = 8;

  localparam logic [31:0] PUSH_BODY_LEN = 32'(PUSH_RECORD_LEN - HEADER_LEN);
  localparam logic [2:0]  DELTA_BYTES   = 3'd4;

  typedef struct packed {
    logic        delta_valid;
    logic [32:0] ts_delta;
    logic        buffer_done;
    logic        status;
  } result_t;

endpackage

FILE: rtl/mcsp_parse_core.sv
// Record parser state and per-item next-state and result logic.
module mcsp_parse_core
  import mcsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output result_t    result,
  output logic       has_result
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_ERROR  = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  command_code, command_code_next;
  logic [7:0]  sub_command, sub_command_next;
  logic [31:0] length_word, length_word_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] delta_word, delta_word_next;
  logic [2:0]  payload_pos, payload_pos_next;
  result_t     res;

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    command_code_next = command_code;
    sub_command_next  = sub_command;
    length_word_next  = length_word;
    bytes_left_next   = bytes_left;
    delta_word_next   = delta_word;
    payload_pos_next  = payload_pos;
    res               = '0;
    unique case (phase)
      PH_HEADER: begin
        if (header_count == 3'd0) begin
          command_code_next = data_byte;
        end
        if (header_count == 3'd4) begin
          sub_command_next = data_byte;
          length_word_next = {24'd0, data_byte};
        end else if (header_count > 3'd4) begin
          length_word_next = {length_word[23:0], data_byte};
        end
        if (header_count == 3'd7) begin
          header_count_next = 3'd0;
          if (command_code == CMD_MEDIA_TIME && sub_command == SUB_FLUSH) begin
            phase_next = PH_HEADER;
          end else if (command_code == CMD_MEDIA_TIME && sub_command == SUB_PUSH) begin
            bytes_left_next = PUSH_BODY_LEN;
            phase_next      = PH_BODY;
          end else if (command_code == CMD_NEW_CELL) begin
            bytes_left_next  = length_word_next;
            payload_pos_next = 3'd0;
            delta_word_next  = 32'd0;
            phase_next       = (length_word_next == 32'd0) ? PH_HEADER : PH_BODY;
          end else begin
            phase_next = PH_ERROR;
          end
        end else begin
          header_count_next = header_count + 3'd1;
        end
      end
      PH_BODY: begin
        if (command_code == CMD_NEW_CELL && length_word >= 32'(DELTA_BYTES) &&
            payload_pos < DELTA_BYTES) begin
          delta_word_next  = {delta_word[23:0], data_byte};
          payload_pos_next = payload_pos + 3'd1;
          if (payload_pos_next == DELTA_BYTES) begin
            res.delta_valid = 1'b1;
            res.ts_delta    = {delta_word_next, 1'b0};
          end
        end
        if (bytes_left != 32'd0) begin
          bytes_left_next = bytes_left - 32'd1;
        end
        if (bytes_left_next == 32'd0) begin
          phase_next        = PH_HEADER;
          header_count_next = 3'd0;
        end
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
    if (end_of_buffer) begin
      res.buffer_done   = 1'b1;
      res.status        = !(phase_next == PH_HEADER && header_count_next == 3'd0);
      phase_next        = PH_HEADER;
      header_count_next = 3'd0;
      command_code_next = 8'd0;
      sub_command_next  = 8'd0;
      length_word_next  = 32'd0;
      bytes_left_next   = 32'd0;
      delta_word_next   = 32'd0;
      payload_pos_next  = 3'd0;
    end
  end

  assign result     = res;
  assign has_result = res.delta_valid || res.buffer_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 3'd0;
      command_code <= 8'd0;
      sub_command  <= 8'd0;
      length_word  <= 32'd0;
      bytes_left   <= 32'd0;
      delta_word   <= 32'd0;
      payload_pos  <= 3'd0;
    end else if (fire) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      command_code <= command_code_next;
      sub_command  <= sub_command_next;
      length_word  <= length_word_next;
      bytes_left   <= bytes_left_next;
      delta_word   <= delta_word_next;
      payload_pos  <= payload_pos_next;
    end
  end

endmodule

FILE: rtl/mcsp_out_reg.sv
// Result register of the output channel.
module mcsp_out_reg
  import mcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        delta_valid,
  output logic [32:0] ts_delta,
  output logic        buffer_done,
  output logic        status
);

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign delta_valid = held.delta_valid;
  assign ts_delta    = held.ts_delta;
  assign buffer_done = held.buffer_done;
  assign status      = held.status;

endmodule

FILE: rtl/media_command_stream_parser.sv
// Top level of the media command stream parser: input register, parser, result register.
//
//   channel  direction  payload                                        handshake
//   in       to block   data_byte, end_of_buffer                       in_valid / in_ready
//   out      from block delta_valid, ts_delta, buffer_done, status     out_valid / out_ready
//
// One byte per cycle unless a held result stalls the input register; as the parse state
// updates from the input register, the byte's result loads into the result register.
// Synchronous reset returns the parser to the header phase and empties both registers.
// A held result stalls the input register only; bytes without a result never stall.
module media_command_stream_parser
  import mcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        delta_valid,
  output logic [32:0] ts_delta,
  output logic        buffer_done,
  output logic        status
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       fire;
  logic       has_result;
  logic       load;
  result_t    result;

  assign fire     = in_full && (!out_valid || out_ready || !has_result);
  assign in_ready = !in_full || fire;
  assign load     = fire && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_last <= end_of_buffer;
    end
  end

  mcsp_parse_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .data_byte     (in_byte),
    .end_of_buffer (in_last),
    .result        (result),
    .has_result    (has_result)
  );

  mcsp_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .result      (result),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .delta_valid (delta_valid),
    .ts_delta    (ts_delta),
    .buffer_done (buffer_done),
    .status      (status)
  );

endmodule

FILE: rtl/mcsp_checker.sv
// Port-level checker of the media command stream parser and its bind.
`include "media_command_stream_parser_macros.svh"

module mcsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        delta_valid,
  input logic [32:0] ts_delta,
  input logic        buffer_done,
  input logic        status
);

  logic        out_stall;
  logic [35:0] out_word;

  assign out_stall = out_valid && !out_ready;
  assign out_word  = {delta_valid, ts_delta, buffer_done, status};

  `MCSP_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_word), "item changed")
  `MCSP_ASSERT(a_item_reason, clk, rst, !out_valid || delta_valid || buffer_done, "empty item")
  `MCSP_ASSERT(a_delta_zero, clk, rst, !out_valid || delta_valid || ts_delta == 33'd0, "stray delta")
  `MCSP_ASSERT(a_delta_even, clk, rst, !(out_valid && delta_valid) || !ts_delta[0], "odd delta")
  `MCSP_ASSERT(a_status_end, clk, rst, !out_valid || buffer_done || !status, "early status")

endmodule

bind media_command_stream_parser mcsp_checker u_checker (.*);
